// ===== rtl/kmer_seed_index_and_match_unit_defines.svh =====
// assertion macros of the k-mer seed index, used by the table engine
`ifndef KMER_SEED_INDEX_AND_MATCH_UNIT_DEFINES_SVH
`define KMER_SEED_INDEX_AND_MATCH_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define KMSI_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("kmsi assertion failed");
// next-cycle implication
`define KMSI_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("kmsi assertion failed");
`else
`define KMSI_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons)
`define KMSI_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== rtl/kmsi_pkg.sv =====
// types, constants and helper functions of the k-mer seed index
package kmsi_pkg;

  localparam int unsigned MaxK        = 64;
  localparam int unsigned KBits       = $clog2(MaxK + 1);
  localparam int unsigned WinBits     = $clog2(MaxK);
  localparam int unsigned SymBits     = 6;
  localparam int unsigned HashBits    = 64;
  localparam logic [31:0] HashBaseLo  = 32'd911382323;
  localparam int unsigned TableSlots  = 4096;
  localparam int unsigned SlotBits    = $clog2(TableSlots);
  localparam int unsigned PosPerKey   = 4;
  localparam int unsigned PosIdxBits  = $clog2(PosPerKey);
  localparam int unsigned CntBits     = $clog2(PosPerKey + 1);
  localparam int unsigned ProbeLimit  = 8;
  localparam int unsigned ProbeBits   = $clog2(ProbeLimit);
  localparam int unsigned PosBits     = 24;
  localparam int unsigned StepBits    = 16;
  localparam int unsigned CapBits     = 24;
  localparam int unsigned ReqBits     = 2;
  localparam int unsigned CfgIdxBits  = 2;
  localparam int unsigned CfgDataBits = 24;
  localparam int unsigned SlotWidth   = 1 + CntBits + HashBits;

  localparam logic [KBits-1:0]    KmerLenReset = KBits'(64);
  localparam logic [StepBits-1:0] StepReset    = StepBits'(256);
  localparam logic [CapBits-1:0]  CapReset     = CapBits'(400000);

  localparam logic [7:0] ChDigitLo = 8'h30;
  localparam logic [7:0] ChDigitHi = 8'h39;
  localparam logic [7:0] ChUpperLo = 8'h41;
  localparam logic [7:0] ChUpperHi = 8'h5A;

  typedef enum logic [ReqBits-1:0] {
    REQ_REF    = 2'd0,
    REQ_QUERY  = 2'd1,
    REQ_CLEAR  = 2'd2,
    REQ_UNUSED = 2'd3
  } req_e;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_KMER_LEN    = 2'd0,
    CFG_SAMPLE_STEP = 2'd1,
    CFG_PAIR_CAP    = 2'd2
  } cfg_e;

  typedef enum logic [2:0] {
    SEEK_INSERT = 3'b001,
    SEEK_LOOKUP = 3'b010,
    SEEK_CLEAR  = 3'b100
  } seek_op_e;

  // request from the hash stage to the table engine
  typedef struct packed {
    logic                valid;
    seek_op_e            op;
    logic [HashBits-1:0] hash;
    logic [PosBits-1:0]  start;
  } seek_t;

  // byte to symbol: digits 1-10, capitals 11-36, else 0
  function automatic logic [SymBits-1:0] sym_of(input logic [7:0] b);
    logic [SymBits-1:0] s;
    s = '0;
    if (b >= ChDigitLo && b <= ChDigitHi) begin
      s = SymBits'(b - ChDigitLo + 8'd1);
    end else if (b >= ChUpperLo && b <= ChUpperHi) begin
      s = SymBits'(b - ChUpperLo + 8'd11);
    end
    return s;
  endfunction

  // window length clamped to 1..MaxK
  function automatic logic [KBits-1:0] eff_k(input logic [KBits-1:0] k);
    logic [KBits-1:0] r;
    r = k;
    if (k == '0) begin
      r = KBits'(1);
    end else if (k > KBits'(MaxK)) begin
      r = KBits'(MaxK);
    end
    return r;
  endfunction

endpackage

// ===== rtl/kmsi_in_if.sv =====
// input word channel of the k-mer seed index
interface kmsi_in_if;
  logic                         valid;
  logic                         ready;
  logic [kmsi_pkg::ReqBits-1:0] req_type;
  logic [7:0]                   symbol_byte;
  logic                         starts_string;

  modport source (output valid, req_type, symbol_byte, starts_string, input ready);
  modport sink (input valid, req_type, symbol_byte, starts_string, output ready);
endinterface

// ===== rtl/kmsi_out_if.sv =====
// result word channel of the k-mer seed index
interface kmsi_out_if;
  logic                         valid;
  logic                         ready;
  logic [kmsi_pkg::PosBits-1:0] ref_pos;
  logic [kmsi_pkg::PosBits-1:0] query_pos;
  logic                         last_pair;

  modport source (output valid, ref_pos, query_pos, last_pair, input ready);
  modport sink (input valid, ref_pos, query_pos, last_pair, output ready);
endinterface

// ===== rtl/kmsi_ram.sv =====
// generic simple dual-port ram, read-first, registered read
module kmsi_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // storage array
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/kmsi_hash.sv =====
// symbol window memory, rolling hash and base power sequencer
module kmsi_hash (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             take_i,
  input  logic [kmsi_pkg::ReqBits-1:0]     type_i,
  input  logic [7:0]                       byte_i,
  input  logic                             start_i,
  input  logic                             cfg_we_i,
  input  logic [kmsi_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [kmsi_pkg::CfgDataBits-1:0] cfg_wdata_i,
  output logic                             idle_o,
  output kmsi_pkg::seek_t                  seek_o
);
  import kmsi_pkg::*;

  typedef enum logic [4:0] {
    H_IDLE = 5'b00001,
    H_MUL  = 5'b00010,
    H_ADD  = 5'b00100,
    H_PMUL = 5'b01000,
    H_PADD = 5'b10000
  } hstate_e;

  hstate_e             state_q, state_d;
  logic [KBits-1:0]    kmer_len_q, kmer_len_d;
  logic [StepBits-1:0] step_q, step_d;
  logic [HashBits-1:0] hash_q, hash_d;
  logic [HashBits-1:0] pow_q, pow_d;
  logic [KBits-1:0]    pow_cnt_q, pow_cnt_d;
  logic [KBits-1:0]    fill_q, fill_d;
  logic [PosBits-1:0]  start_q, start_d;
  logic [StepBits-1:0] phase_q, phase_d;
  logic [WinBits-1:0]  head_q, head_d;
  logic [SymBits-1:0]  sym_q, sym_d;
  logic                is_ref_q, is_ref_d;
  logic                full_q, full_d;
  logic [HashBits-1:0] lo_q, lo_d;
  logic [31:0]         hi_q, hi_d;
  logic [HashBits-1:0] old_q, old_d;
  seek_t               seek_q, seek_d;

  logic [KBits-1:0]    k_eff;
  logic [StepBits-1:0] step_eff;
  logic [WinBits-1:0]  head_use;
  logic [WinBits-1:0]  head_nxt;
  logic [HashBits-1:0] opnd;
  logic [HashBits-1:0] sum;
  logic [StepBits:0]   phase_inc;
  logic [StepBits-1:0] phase_step;
  logic [StepBits-1:0] phase_new;
  logic [PosBits-1:0]  start_new;
  logic                win_full;
  logic                win_we;
  logic [SymBits-1:0]  win_rdata;
  logic [SymBits-1:0]  sym_in;

  assign k_eff    = eff_k(kmer_len_q);
  assign step_eff = (step_q == '0) ? StepBits'(1) : step_q;
  assign sym_in   = sym_of(byte_i);

  // window slot of the incoming symbol
  always_comb begin
    if (start_i || (KBits'(head_q) >= k_eff)) begin
      head_use = '0;
    end else begin
      head_use = head_q;
    end
    if (KBits'(head_use) + KBits'(1) >= k_eff) begin
      head_nxt = '0;
    end else begin
      head_nxt = head_use + WinBits'(1);
    end
  end

  kmsi_ram #(
    .Width (SymBits),
    .Depth (MaxK)
  ) u_win_ram (
    .clk_i   (clk_i),
    .we_i    (win_we),
    .waddr_i (head_use),
    .wdata_i (sym_in),
    .re_i    (win_we),
    .raddr_i (head_use),
    .rdata_o (win_rdata)
  );

  // shared 32x32 multipliers: hash or base power times the base
  assign opnd = (state_q == H_PMUL) ? pow_q : hash_q;
  assign lo_d = opnd[31:0] * HashBaseLo;
  assign hi_d = opnd[63:32] * HashBaseLo;
  assign old_d = pow_q * win_rdata;

  // hash update and window advance
  assign sum = lo_q + {hi_q, 32'b0} + HashBits'(sym_q) - (full_q ? old_q : '0);
  assign phase_inc  = {1'b0, phase_q} + (StepBits+1)'(1);
  assign phase_step = (phase_inc >= {1'b0, step_eff}) ? '0 : phase_inc[StepBits-1:0];
  assign phase_new  = full_q ? phase_step : phase_q;
  assign start_new  = full_q ? (start_q + PosBits'(1)) : start_q;
  assign win_full   = full_q || ((fill_q + KBits'(1)) >= k_eff);

  // sequencer
  always_comb begin
    state_d    = state_q;
    kmer_len_d = kmer_len_q;
    step_d     = step_q;
    hash_d     = hash_q;
    pow_d      = pow_q;
    pow_cnt_d  = pow_cnt_q;
    fill_d     = fill_q;
    start_d    = start_q;
    phase_d    = phase_q;
    head_d     = head_q;
    sym_d      = sym_q;
    is_ref_d   = is_ref_q;
    full_d     = full_q;
    seek_d     = '0;
    seek_d.op  = SEEK_CLEAR;
    win_we     = 1'b0;
    unique case (state_q)
      H_IDLE: begin
        if (take_i) begin
          unique case (req_e'(type_i))
            REQ_REF, REQ_QUERY: begin
              win_we   = 1'b1;
              head_d   = head_nxt;
              sym_d    = sym_in;
              is_ref_d = (req_e'(type_i) == REQ_REF);
              if (start_i) begin
                hash_d  = '0;
                fill_d  = '0;
                start_d = '0;
                phase_d = '0;
                full_d  = 1'b0;
              end else begin
                full_d  = (fill_q >= k_eff);
              end
              state_d = H_MUL;
            end
            REQ_CLEAR: begin
              seek_d.valid = 1'b1;
              seek_d.op    = SEEK_CLEAR;
            end
            default: ;
          endcase
        end
      end
      H_MUL: begin
        state_d = H_ADD;
      end
      H_ADD: begin
        hash_d  = sum;
        start_d = start_new;
        phase_d = phase_new;
        if (!full_q) begin
          fill_d = fill_q + KBits'(1);
        end
        if (win_full && (phase_new == '0)) begin
          seek_d.valid = 1'b1;
          seek_d.op    = is_ref_q ? SEEK_INSERT : SEEK_LOOKUP;
          seek_d.hash  = sum;
          seek_d.start = start_new;
        end
        state_d = H_IDLE;
      end
      H_PMUL: begin
        state_d = H_PADD;
      end
      H_PADD: begin
        pow_d     = lo_q + {hi_q, 32'b0};
        pow_cnt_d = pow_cnt_q - KBits'(1);
        state_d   = (pow_cnt_q == KBits'(1)) ? H_IDLE : H_PMUL;
      end
      default: state_d = H_IDLE;
    endcase
    // register writes
    if (cfg_we_i) begin
      unique case (cfg_e'(cfg_idx_i))
        CFG_KMER_LEN: begin
          kmer_len_d = cfg_wdata_i[KBits-1:0];
          pow_d      = HashBits'(1);
          pow_cnt_d  = eff_k(cfg_wdata_i[KBits-1:0]);
          hash_d     = '0;
          fill_d     = '0;
          start_d    = '0;
          phase_d    = '0;
          head_d     = '0;
          state_d    = H_PMUL;
        end
        CFG_SAMPLE_STEP: step_d = cfg_wdata_i[StepBits-1:0];
        default: ;
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= H_PMUL;
      kmer_len_q <= KmerLenReset;
      step_q     <= StepReset;
      pow_q      <= HashBits'(1);
      pow_cnt_q  <= eff_k(KmerLenReset);
      hash_q     <= '0;
      fill_q     <= '0;
      start_q    <= '0;
      phase_q    <= '0;
      head_q     <= '0;
      seek_q     <= '0;
    end else begin
      state_q    <= state_d;
      kmer_len_q <= kmer_len_d;
      step_q     <= step_d;
      pow_q      <= pow_d;
      pow_cnt_q  <= pow_cnt_d;
      hash_q     <= hash_d;
      fill_q     <= fill_d;
      start_q    <= start_d;
      phase_q    <= phase_d;
      head_q     <= head_d;
      seek_q     <= seek_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    sym_q    <= sym_d;
    is_ref_q <= is_ref_d;
    full_q   <= full_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    old_q    <= old_d;
  end

  assign idle_o = (state_q == H_IDLE) && !seek_q.valid;
  assign seek_o = seek_q;

endmodule

// ===== rtl/kmsi_table.sv =====
// hash table engine: clearing sweep, probe, insert and pair emission
`include "kmer_seed_index_and_match_unit_defines.svh"
module kmsi_table (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  kmsi_pkg::seek_t                  seek_i,
  input  logic                             cfg_we_i,
  input  logic [kmsi_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [kmsi_pkg::CfgDataBits-1:0] cfg_wdata_i,
  output logic                             idle_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [kmsi_pkg::PosBits-1:0]     ref_pos_o,
  output logic [kmsi_pkg::PosBits-1:0]     query_pos_o,
  output logic                             last_pair_o
);
  import kmsi_pkg::*;

  typedef enum logic [4:0] {
    T_CLR   = 5'b00001,
    T_IDLE  = 5'b00010,
    T_PROBE = 5'b00100,
    T_QRD   = 5'b01000,
    T_QOUT  = 5'b10000
  } tstate_e;

  localparam int unsigned PosAddrBits = SlotBits + PosIdxBits;

  tstate_e             state_q, state_d;
  logic [SlotBits-1:0] clr_q, clr_d;
  logic [SlotBits-1:0] slot_q, slot_d;
  logic [ProbeBits-1:0] probe_q, probe_d;
  logic [HashBits-1:0] hash_q, hash_d;
  logic [PosBits-1:0]  start_q, start_d;
  logic                ins_q, ins_d;
  logic [CntBits-1:0]  cnt_q, cnt_d;
  logic [CntBits-1:0]  t_q, t_d;
  logic [CapBits-1:0]  pairs_q, pairs_d;
  logic [CapBits-1:0]  cap_q, cap_d;
  logic                out_valid_q, out_valid_d;
  logic [PosBits-1:0]  out_ref_q, out_ref_d;
  logic [PosBits-1:0]  out_qry_q, out_qry_d;
  logic                out_last_q, out_last_d;

  logic                 slot_we, slot_re;
  logic [SlotBits-1:0]  slot_waddr, slot_raddr;
  logic [SlotWidth-1:0] slot_wdata, slot_rdata;
  logic                 pos_we, pos_re;
  logic [PosAddrBits-1:0] pos_waddr;
  logic [PosBits-1:0]   pos_rdata;
  logic                 rd_used;
  logic [CntBits-1:0]   rd_cnt;
  logic [CntBits-1:0]   rd_cnt_eff;
  logic [HashBits-1:0]  rd_key;
  logic [HashBits-1:0]  mix;
  logic [CntBits-1:0]   wr_cnt;
  logic [CapBits:0]     pairs_inc;
  logic                 emit;
  logic                 last_d;

  assign mix    = seek_i.hash ^ (seek_i.hash >> 32) ^ (seek_i.hash >> 16);
  assign rd_used = slot_rdata[SlotWidth-1];
  assign rd_cnt  = slot_rdata[SlotWidth-2 -: CntBits];
  assign rd_key  = slot_rdata[HashBits-1:0];
  assign rd_cnt_eff = (rd_cnt > CntBits'(PosPerKey)) ? CntBits'(PosPerKey) : rd_cnt;
  assign wr_cnt  = slot_wdata[SlotWidth-2 -: CntBits];
  assign pairs_inc = {1'b0, pairs_q} + (CapBits+1)'(1);
  assign last_d  = ((t_q + CntBits'(1)) == cnt_q) || (pairs_inc >= {1'b0, cap_q});
  assign emit    = (state_q == T_QOUT) && (!out_valid_q || out_ready_i);

  kmsi_ram #(
    .Width (SlotWidth),
    .Depth (TableSlots)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (slot_wdata),
    .re_i    (slot_re),
    .raddr_i (slot_raddr),
    .rdata_o (slot_rdata)
  );

  kmsi_ram #(
    .Width (PosBits),
    .Depth (TableSlots * PosPerKey)
  ) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (pos_we),
    .waddr_i (pos_waddr),
    .wdata_i (start_q),
    .re_i    (pos_re),
    .raddr_i ({slot_q, t_q[PosIdxBits-1:0]}),
    .rdata_o (pos_rdata)
  );

  // engine
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    slot_d      = slot_q;
    probe_d     = probe_q;
    hash_d      = hash_q;
    start_d     = start_q;
    ins_d       = ins_q;
    cnt_d       = cnt_q;
    t_d         = t_q;
    pairs_d     = pairs_q;
    cap_d       = cap_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_ref_d   = out_ref_q;
    out_qry_d   = out_qry_q;
    out_last_d  = out_last_q;
    slot_we     = 1'b0;
    slot_waddr  = slot_q;
    slot_wdata  = '0;
    slot_re     = 1'b0;
    slot_raddr  = slot_q + SlotBits'(1);
    pos_we      = 1'b0;
    pos_waddr   = {slot_q, rd_cnt[PosIdxBits-1:0]};
    pos_re      = 1'b0;
    unique case (state_q)
      T_CLR: begin
        slot_we    = 1'b1;
        slot_waddr = clr_q;
        clr_d      = clr_q + SlotBits'(1);
        if (clr_q == '1) begin
          state_d = T_IDLE;
        end
      end
      T_IDLE: begin
        if (seek_i.valid) begin
          unique case (seek_i.op)
            SEEK_CLEAR: begin
              clr_d   = '0;
              pairs_d = '0;
              state_d = T_CLR;
            end
            SEEK_INSERT, SEEK_LOOKUP: begin
              hash_d     = seek_i.hash;
              start_d    = seek_i.start;
              ins_d      = (seek_i.op == SEEK_INSERT);
              slot_d     = mix[SlotBits-1:0];
              slot_re    = 1'b1;
              slot_raddr = mix[SlotBits-1:0];
              probe_d    = '0;
              state_d    = T_PROBE;
            end
            default: ;
          endcase
        end
      end
      T_PROBE: begin
        if (!rd_used) begin
          // free slot: an insert starts a new key here, a lookup ends
          if (ins_q) begin
            slot_we    = 1'b1;
            slot_wdata = {1'b1, CntBits'(1), hash_q};
            pos_we     = 1'b1;
            pos_waddr  = {slot_q, {PosIdxBits{1'b0}}};
          end
          state_d = T_IDLE;
        end else if (rd_key == hash_q) begin
          if (ins_q) begin
            if (rd_cnt < CntBits'(PosPerKey)) begin
              slot_we    = 1'b1;
              slot_wdata = {1'b1, rd_cnt + CntBits'(1), rd_key};
              pos_we     = 1'b1;
            end
            state_d = T_IDLE;
          end else if ((rd_cnt_eff != '0) && (pairs_q < cap_q)) begin
            cnt_d   = rd_cnt_eff;
            t_d     = '0;
            state_d = T_QRD;
          end else begin
            state_d = T_IDLE;
          end
        end else if (probe_q == ProbeBits'(ProbeLimit - 1)) begin
          state_d = T_IDLE;
        end else begin
          probe_d = probe_q + ProbeBits'(1);
          slot_d  = slot_q + SlotBits'(1);
          slot_re = 1'b1;
        end
      end
      T_QRD: begin
        pos_re  = 1'b1;
        state_d = T_QOUT;
      end
      T_QOUT: begin
        if (emit) begin
          out_valid_d = 1'b1;
          out_ref_d   = pos_rdata;
          out_qry_d   = start_q;
          out_last_d  = last_d;
          pairs_d     = pairs_inc[CapBits-1:0];
          t_d         = t_q + CntBits'(1);
          state_d     = last_d ? T_IDLE : T_QRD;
        end
      end
      default: state_d = T_IDLE;
    endcase
    if (cfg_we_i && (cfg_e'(cfg_idx_i) == CFG_PAIR_CAP)) begin
      cap_d = cfg_wdata_i[CapBits-1:0];
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_CLR;
      clr_q       <= '0;
      pairs_q     <= '0;
      cap_q       <= CapReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      pairs_q     <= pairs_d;
      cap_q       <= cap_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    slot_q     <= slot_d;
    probe_q    <= probe_d;
    hash_q     <= hash_d;
    start_q    <= start_d;
    ins_q      <= ins_d;
    cnt_q      <= cnt_d;
    t_q        <= t_d;
    out_ref_q  <= out_ref_d;
    out_qry_q  <= out_qry_d;
    out_last_q <= out_last_d;
  end

  assign idle_o      = (state_q == T_IDLE);
  assign out_valid_o = out_valid_q;
  assign ref_pos_o   = out_ref_q;
  assign query_pos_o = out_qry_q;
  assign last_pair_o = out_last_q;

  // requests only arrive while the engine is free
  `KMSI_ASSERT_IMPLIES(a_seek_idle, clk_i, rst_ni, seek_i.valid, state_q == T_IDLE)
  // a key never holds more positions than it has room for
  `KMSI_ASSERT_IMPLIES(a_cnt_bound, clk_i, rst_ni, slot_we, wr_cnt <= CntBits'(PosPerKey))
  // the last pair of a lookup frees the engine
  `KMSI_ASSERT_NEXT(a_last_frees, clk_i, rst_ni, emit && last_d, state_q == T_IDLE)

endmodule

// ===== rtl/kmer_seed_index_and_match_unit.sv =====
// top level of the streaming k-mer seed index and matcher
// One word is taken at a time. A reference or query byte passes through a window memory
// read, a 32x32 multiply stage and a hash add. A sampled window is handed to the table
// engine through a register; the engine then reads one slot per cycle over one to eight
// probes, an insert being written to the last one if it is free or holds the key with room.
// A lookup emits each pair through a position memory read, then the output register, held
// while the result side stalls. The output register lets a waiting pair sit while the next
// word is taken. A clear word and reset each start a sweep of all 4096 slots, one slot
// per cycle, with ready low. Writing kmer_len (and reset) recomputes the base power with
// ready low by repeated multiplication, a multiply and an add step per window symbol.
module kmer_seed_index_and_match_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  kmsi_in_if.sink                          in_if,
  kmsi_out_if.source                       out_if,
  input  logic                             cfg_we_i,
  input  logic [kmsi_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [kmsi_pkg::CfgDataBits-1:0] cfg_wdata_i
);
  import kmsi_pkg::*;

  logic  hash_idle;
  logic  table_idle;
  logic  take;
  seek_t seek;

  // one word in flight at a time
  assign in_if.ready = hash_idle && table_idle;
  assign take        = in_if.valid && in_if.ready;

  kmsi_hash u_hash (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .type_i      (in_if.req_type),
    .byte_i      (in_if.symbol_byte),
    .start_i     (in_if.starts_string),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .idle_o      (hash_idle),
    .seek_o      (seek)
  );

  kmsi_table u_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .seek_i      (seek),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .idle_o      (table_idle),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .ref_pos_o   (out_if.ref_pos),
    .query_pos_o (out_if.query_pos),
    .last_pair_o (out_if.last_pair)
  );

endmodule
